// File: rtl/trg_pkg.sv
package trg_pkg;

  localparam int COORD_BITS = 16;
  localparam int PART_BITS  = 8;
  // size * (idx + 1) needs one bit beyond the index width
  localparam int NUM_BITS   = COORD_BITS + PART_BITS + 1;
  localparam int NUM_JOBS   = 8;
  localparam int JOB_BITS   = 3;
  localparam int CFG_BITS   = 2;

  localparam logic [CFG_BITS-1:0] CFG_BATCH_PARTS = 2'd0;
  localparam logic [CFG_BITS-1:0] CFG_CHAN_PARTS  = 2'd1;
  localparam logic [CFG_BITS-1:0] CFG_ROW_PARTS   = 2'd2;
  localparam logic [CFG_BITS-1:0] CFG_COL_PARTS   = 2'd3;

  localparam logic [1:0] DIM_BATCH = 2'd0;
  localparam logic [1:0] DIM_CHAN  = 2'd1;
  localparam logic [1:0] DIM_ROW   = 2'd2;
  localparam logic [1:0] DIM_COL   = 2'd3;

  typedef struct packed {
    logic [COORD_BITS-1:0] batch_start;
    logic [COORD_BITS-1:0] batch_end;
    logic [COORD_BITS-1:0] chan_start;
    logic [COORD_BITS-1:0] chan_end;
    logic [COORD_BITS-1:0] row_start;
    logic [COORD_BITS-1:0] row_end;
    logic [COORD_BITS-1:0] col_start;
    logic [COORD_BITS-1:0] col_end;
  } range_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] tile_batch_start;
    logic [COORD_BITS-1:0] tile_batch_end;
    logic [COORD_BITS-1:0] tile_chan_start;
    logic [COORD_BITS-1:0] tile_chan_end;
    logic [COORD_BITS-1:0] tile_row_start;
    logic [COORD_BITS-1:0] tile_row_end;
    logic [COORD_BITS-1:0] tile_col_start;
    logic [COORD_BITS-1:0] tile_col_end;
    logic                  last_tile;
  } tile_t;

  typedef struct packed {
    logic [PART_BITS-1:0] batch_parts;
    logic [PART_BITS-1:0] chan_parts;
    logic [PART_BITS-1:0] row_parts;
    logic [PART_BITS-1:0] col_parts;
  } parts_t;

  typedef struct packed {
    logic                 start;
    logic [NUM_BITS-1:0]  num;
    logic [PART_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [NUM_BITS-1:0] quot;
  } div_rsp_t;

  // a zero part count behaves as one
  function automatic logic [PART_BITS-1:0] eff_parts(input logic [PART_BITS-1:0] p);
    eff_parts = (p == '0) ? PART_BITS'(1) : p;
  endfunction

endpackage

// File: rtl/trg_div.sv
module trg_div
  import trg_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  logic                 busy;
  logic                 done;
  logic [CNT_BITS-1:0]  cnt;
  logic [NUM_BITS-1:0]  num;
  logic [PART_BITS-1:0] rem;
  logic [PART_BITS-1:0] den;

  logic [PART_BITS:0]   shifted;
  logic [PART_BITS:0]   diff;
  logic                 ge;

  assign shifted = {rem, num[NUM_BITS-1]};
  assign ge      = shifted >= {1'b0, den};
  assign diff    = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(NUM_BITS);
      end else if (busy) begin
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit per cycle shifted into num
  always_ff @(posedge clk) begin
    if (req.start) begin
      num <= req.num;
      den <= req.den;
      rem <= '0;
    end else if (busy) begin
      num <= {num[NUM_BITS-2:0], ge};
      rem <= ge ? diff[PART_BITS-1:0] : shifted[PART_BITS-1:0];
    end
  end

  assign rsp.done = done;
  assign rsp.quot = num;

endmodule

// File: rtl/trg_ctrl.sv
module trg_ctrl
  import trg_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     range_valid,
  output logic     range_stall,
  input  range_t   range_data,
  input  parts_t   parts,
  input  logic     out_free,
  output logic     load,
  output tile_t    result,
  output div_req_t div_req,
  input  div_rsp_t div_rsp
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SIZE = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_HOLD = 3'd5;

  logic [2:0]            state;
  logic [JOB_BITS-1:0]   job;
  range_t                rng;
  logic [COORD_BITS-1:0] size;
  logic [NUM_BITS-1:0]   prod;
  logic [COORD_BITS-1:0] res [NUM_JOBS];

  logic [PART_BITS-1:0]  batch_idx, chan_idx, row_idx, col_idx;

  logic [1:0]            dim;
  logic                  hi;
  logic [COORD_BITS-1:0] s_sel, e_sel;
  logic [PART_BITS-1:0]  p_sel, i_sel;
  logic [COORD_BITS-1:0] size_calc;
  logic [PART_BITS:0]    mult_op;
  logic [NUM_BITS-1:0]   prod_calc;
  logic [COORD_BITS-1:0] res_calc;

  logic [PART_BITS:0]    nb, nh, nr, nc;
  logic                  bw, hw, rw, cw;

  assign dim = job[JOB_BITS-1:1];
  assign hi  = job[0];

  always_comb begin
    unique case (dim)
      DIM_BATCH: begin
        s_sel = rng.batch_start;
        e_sel = rng.batch_end;
        p_sel = parts.batch_parts;
        i_sel = batch_idx;
      end
      DIM_CHAN: begin
        s_sel = rng.chan_start;
        e_sel = rng.chan_end;
        p_sel = parts.chan_parts;
        i_sel = chan_idx;
      end
      DIM_ROW: begin
        s_sel = rng.row_start;
        e_sel = rng.row_end;
        p_sel = parts.row_parts;
        i_sel = row_idx;
      end
      DIM_COL: begin
        s_sel = rng.col_start;
        e_sel = rng.col_end;
        p_sel = parts.col_parts;
        i_sel = col_idx;
      end
      default: begin
        s_sel = rng.col_start;
        e_sel = rng.col_end;
        p_sel = parts.col_parts;
        i_sel = col_idx;
      end
    endcase
  end

  // reversed range gives an empty tile at the start
  assign size_calc = (e_sel >= s_sel) ? (e_sel - s_sel) : '0;
  assign mult_op   = {1'b0, i_sel} + (PART_BITS + 1)'(hi);
  assign prod_calc = NUM_BITS'(size) * NUM_BITS'(mult_op);
  assign res_calc  = s_sel + div_rsp.quot[COORD_BITS-1:0];

  assign div_req.start = (state == S_DIV);
  assign div_req.num   = prod;
  assign div_req.den   = eff_parts(p_sel);

  // coordinate step: column fastest, batch slowest
  assign nc = {1'b0, col_idx} + (PART_BITS + 1)'(1);
  assign nr = {1'b0, row_idx} + (PART_BITS + 1)'(1);
  assign nh = {1'b0, chan_idx} + (PART_BITS + 1)'(1);
  assign nb = {1'b0, batch_idx} + (PART_BITS + 1)'(1);
  assign cw = nc >= {1'b0, eff_parts(parts.col_parts)};
  assign rw = nr >= {1'b0, eff_parts(parts.row_parts)};
  assign hw = nh >= {1'b0, eff_parts(parts.chan_parts)};
  assign bw = nb >= {1'b0, eff_parts(parts.batch_parts)};

  assign range_stall = (state != S_IDLE);
  assign load        = (state == S_HOLD) && out_free;

  always_comb begin
    result.tile_batch_start = res[0];
    result.tile_batch_end   = res[1];
    result.tile_chan_start  = res[2];
    result.tile_chan_end    = res[3];
    result.tile_row_start   = res[4];
    result.tile_row_end     = res[5];
    result.tile_col_start   = res[6];
    result.tile_col_end     = res[7];
    result.last_tile        = cw && rw && hw && bw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      job       <= '0;
      batch_idx <= '0;
      chan_idx  <= '0;
      row_idx   <= '0;
      col_idx   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (range_valid) begin
            job   <= '0;
            state <= S_SIZE;
          end
        end
        S_SIZE: state <= S_MUL;
        S_MUL:  state <= S_DIV;
        S_DIV:  state <= S_WAIT;
        S_WAIT: begin
          if (div_rsp.done) begin
            if (job == JOB_BITS'(NUM_JOBS - 1)) begin
              state <= S_HOLD;
            end else begin
              job   <= job + JOB_BITS'(1);
              state <= S_SIZE;
            end
          end
        end
        S_HOLD: begin
          if (out_free) begin
            state   <= S_IDLE;
            col_idx <= cw ? '0 : nc[PART_BITS-1:0];
            if (cw) begin
              row_idx <= rw ? '0 : nr[PART_BITS-1:0];
              if (rw) begin
                chan_idx <= hw ? '0 : nh[PART_BITS-1:0];
                if (hw) begin
                  batch_idx <= bw ? '0 : nb[PART_BITS-1:0];
                end
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && range_valid) begin
      rng <= range_data;
    end
    if (state == S_SIZE) begin
      size <= size_calc;
    end
    if (state == S_MUL) begin
      prod <= prod_calc;
    end
    if (state == S_WAIT && div_rsp.done) begin
      res[job] <= res_calc;
    end
  end

endmodule

// File: rtl/tile_range_generator_top.sv
// Tile range generator.
// Input channel (range_valid / range_stall / range_data) takes a 4-D range:
// batch, channel, row and column, each a start and an end one past it. For
// each range the block returns one tile descriptor on the output channel
// (tile_valid / tile_stall / tile_data): the sub-range of the current tile
// in every dimension, start + size*idx/parts .. start + size*(idx+1)/parts,
// and last_tile on the tile after which the coordinate wraps to zero. The
// coordinate then steps, column fastest, batch slowest.
// Part counts are written on cfg_we / cfg_index / cfg_data while idle.
// One shared restoring divider producing one quotient bit per cycle does the
// eight divisions, one per tile bound, in turn.
// range_stall stays high from acceptance until the descriptor moves into
// the output register, so the next range is taken while a finished tile
// waits there. A stalled tile holds; the next one waits in the sequencer.
// Reset clears the tile coordinate to zero and all part counts to one.
module tile_range_generator_top
  import trg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 range_valid,
  output logic                 range_stall,
  input  range_t               range_data,
  output logic                 tile_valid,
  input  logic                 tile_stall,
  output tile_t                tile_data,
  input  logic                 cfg_we,
  input  logic [CFG_BITS-1:0]  cfg_index,
  input  logic [PART_BITS-1:0] cfg_data
);

  parts_t   parts;
  logic     out_free;
  logic     load;
  tile_t    result;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign out_free = !tile_valid || !tile_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      parts.batch_parts <= PART_BITS'(1);
      parts.chan_parts  <= PART_BITS'(1);
      parts.row_parts   <= PART_BITS'(1);
      parts.col_parts   <= PART_BITS'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BATCH_PARTS: parts.batch_parts <= cfg_data;
        CFG_CHAN_PARTS:  parts.chan_parts  <= cfg_data;
        CFG_ROW_PARTS:   parts.row_parts   <= cfg_data;
        CFG_COL_PARTS:   parts.col_parts   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_valid <= 1'b0;
    end else if (load) begin
      tile_valid <= 1'b1;
    end else if (!tile_stall) begin
      tile_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tile_data <= result;
    end
  end

  trg_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .range_valid (range_valid),
    .range_stall (range_stall),
    .range_data  (range_data),
    .parts       (parts),
    .out_free    (out_free),
    .load        (load),
    .result      (result),
    .div_req     (div_req),
    .div_rsp     (div_rsp)
  );

  trg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule

// File: rtl/trg_checker.sv
module trg_checker
  import trg_pkg::*;
(
  input logic   clk,
  input logic   rst,
  input logic   range_valid,
  input logic   range_stall,
  input logic   tile_valid,
  input logic   tile_stall,
  input tile_t  tile_data
);

  // a taken range keeps the block busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    range_valid && !range_stall |=> range_stall)
    else $error("range taken while block still free");

  // a new tile only comes out of a busy sequencer
  a_tile_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(tile_valid) |-> $past(range_stall))
    else $error("tile appeared without work in progress");

  a_tile_hold: assert property (@(posedge clk) disable iff (rst)
    tile_valid && tile_stall |=> tile_valid && $stable(tile_data))
    else $error("stalled tile transaction changed");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !tile_valid && !range_stall)
    else $error("output or busy state survived reset");

endmodule

bind tile_range_generator_top trg_checker u_trg_checker (
  .clk         (clk),
  .rst         (rst),
  .range_valid (range_valid),
  .range_stall (range_stall),
  .tile_valid  (tile_valid),
  .tile_stall  (tile_stall),
  .tile_data   (tile_data)
);
